### hw/rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants for the first-fit range allocator: field
// widths, opcodes, slot kinds, status codes and controller/datapath links.
// ----------------------------------------------------------------------------
package ffra_pkg;

   // Parameter defaults
   localparam int SLOT_COUNT_DEF = 32;
   localparam int ADDR_BITS_DEF  = 32;

   // Fixed port field widths
   localparam int FIELD_ADDR_BITS = 32;
   localparam int SIZE_BITS       = 32;
   localparam int SLOT_FIELD_BITS = 5;
   localparam int CSR_IDX_BITS    = 4;
   localparam int CSR_DATA_BITS   = 32;

   // Opcodes
   localparam logic [1:0] OP_FORMAT  = 2'd0;
   localparam logic [1:0] OP_ALLOC   = 2'd1;
   localparam logic [1:0] OP_REGION  = 2'd2;
   localparam logic [1:0] OP_ITERATE = 2'd3;

   // Slot kinds
   localparam logic [1:0] KIND_UNUSED = 2'd0;
   localparam logic [1:0] KIND_FREE   = 2'd1;
   localparam logic [1:0] KIND_FILE   = 2'd2;
   localparam logic [1:0] KIND_DIR    = 2'd3;

   // Response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_NONE  = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_POOL_START = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_POOL_END   = 4'd1;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_NEW,
      S_FIX,
      S_SPLIT,
      S_FORMAT
   } state_type;

   // Table write selects
   typedef enum logic [2:0] {
      WR_NONE,
      WR_FORMAT,
      WR_NEW,
      WR_HEAD,
      WR_TAIL,
      WR_SPLIT,
      WR_DROP
   } wr_sel_type;

   // Response payload sources
   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_FORMAT,
      SRC_NEW,
      SRC_FOUND
   } rsp_src_type;

   typedef struct packed {
      logic        load;
      logic        scan_issue;
      wr_sel_type  wr_sel;
      logic        respond;
      logic [1:0]  rsp_status;
      rsp_src_type rsp_src;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       f_found;
      logic       u_found;
      logic       v_found;
      logic       head_eq;
      logic       tail_eq;
      logic       exact;
      logic       issue_last;
   } stat_type;

endpackage

### hw/rtl/first_fit_range_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator_core
// First-fit allocator over a table of address-range slots.
//
// Usage: drive the req_ fields and pulse start while busy is low; the
// request is taken at that edge. Opcodes: format, allocate by size,
// allocate a given region, iterate from a slot. One response follows each
// request: rsp_strobe is high for one cycle with status, slot, kind and
// range on the rsp_ ports. The receiver cannot stall; take it that cycle.
// Format responds without a scan. Other requests scan the table one slot
// per cycle through the table RAM read port. Iterate and failed requests
// then respond; a successful allocation first updates the table, a region
// split with three table writes.
// busy drops in the cycle the response is on the rsp_ ports, so the next
// request can start while it is there.
// The user must write pool_start and pool_end over the csr_ port only while idle; the block does not enforce it.
// Reset: all slots unused, pool covers the full address space; no
// clearing pass is needed, the in-use bits clear at once.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_core
   import ffra_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_IDX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_opcode,
   input  logic [SIZE_BITS-1:0]       req_alloc_size,
   input  logic [FIELD_ADDR_BITS-1:0] req_region_start,
   input  logic [FIELD_ADDR_BITS-1:0] req_region_end,
   input  logic [1:0]                 req_entry_kind,
   input  logic [SLOT_FIELD_BITS-1:0] req_slot_index,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_status,
   output logic [SLOT_FIELD_BITS-1:0] rsp_result_slot,
   output logic [1:0]                 rsp_result_kind,
   output logic [FIELD_ADDR_BITS-1:0] rsp_result_start,
   output logic [FIELD_ADDR_BITS-1:0] rsp_result_end
);

   cmd_type  cmd;
   stat_type stat;

   ffra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   ffra_dp #(
      .SLOT_COUNT (SLOT_COUNT),
      .ADDR_BITS  (ADDR_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_opcode       (req_opcode),
      .req_alloc_size   (req_alloc_size),
      .req_region_start (req_region_start),
      .req_region_end   (req_region_end),
      .req_entry_kind   (req_entry_kind),
      .req_slot_index   (req_slot_index),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_result_slot  (rsp_result_slot),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_result_start (rsp_result_start),
      .rsp_result_end   (rsp_result_end)
   );

endmodule

### hw/rtl/ffra_ram.sv
// ----------------------------------------------------------------------------
// ffra_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module ffra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ffra_dp.sv
// ----------------------------------------------------------------------------
// ffra_dp
// Allocator datapath: request and pool registers, slot table RAM with
// in-use bits, scan pointer, candidate slot capture, table updates and
// the response register.
// ----------------------------------------------------------------------------
module ffra_dp
   import ffra_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_IDX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic [1:0]                 req_opcode,
   input  logic [SIZE_BITS-1:0]       req_alloc_size,
   input  logic [FIELD_ADDR_BITS-1:0] req_region_start,
   input  logic [FIELD_ADDR_BITS-1:0] req_region_end,
   input  logic [1:0]                 req_entry_kind,
   input  logic [SLOT_FIELD_BITS-1:0] req_slot_index,
   input  cmd_type                    cmd,
   output stat_type                   stat,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_status,
   output logic [SLOT_FIELD_BITS-1:0] rsp_result_slot,
   output logic [1:0]                 rsp_result_kind,
   output logic [FIELD_ADDR_BITS-1:0] rsp_result_start,
   output logic [FIELD_ADDR_BITS-1:0] rsp_result_end
);

   // Stored address width: the parameter, capped by the field width
   localparam int AW = (ADDR_BITS < FIELD_ADDR_BITS) ? ADDR_BITS : FIELD_ADDR_BITS;
   localparam int SW = $clog2(SLOT_COUNT);
   localparam int EW = 2 + 2 * AW;

   // Configuration registers
   logic [AW-1:0] pool_start_ff, pool_start_in;
   logic [AW-1:0] pool_end_ff, pool_end_in;

   // Request registers
   logic [1:0]                 op_ff, op_in;
   logic [SIZE_BITS-1:0]       size_ff, size_in;
   logic [AW-1:0]              rs_ff, rs_in;
   logic [AW-1:0]              re_ff, re_in;
   logic [1:0]                 kind_ff, kind_in;
   logic [SLOT_FIELD_BITS-1:0] idx_ff, idx_in;

   // Scan control
   logic [SW-1:0] scan_ptr_ff, scan_ptr_in;
   logic [SW-1:0] eval_ptr_ff, eval_ptr_in;
   logic          eval_vld_ff, eval_vld_in;

   // Candidate slots
   logic          f_found_ff, f_found_in;
   logic [SW-1:0] f_slot_ff, f_slot_in;
   logic [1:0]    f_kind_ff, f_kind_in;
   logic [AW-1:0] f_first_ff, f_first_in;
   logic [AW-1:0] f_last_ff, f_last_in;
   logic          u_found_ff, u_found_in;
   logic [SW-1:0] u_slot_ff, u_slot_in;
   logic          v_found_ff, v_found_in;
   logic [SW-1:0] v_slot_ff, v_slot_in;

   // In-use bits, one per slot
   logic [SLOT_COUNT-1:0] used_ff, used_in;

   // Response registers
   logic                       rsp_vld_ff, rsp_vld_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic [SLOT_FIELD_BITS-1:0] rsp_slot_ff, rsp_slot_in;
   logic [1:0]                 rsp_kind_ff, rsp_kind_in;
   logic [FIELD_ADDR_BITS-1:0] rsp_start_ff, rsp_start_in;
   logic [FIELD_ADDR_BITS-1:0] rsp_end_ff, rsp_end_in;

   // Table RAM ports
   logic          ram_we;
   logic [SW-1:0] ram_waddr;
   logic [EW-1:0] ram_wdata;
   logic [EW-1:0] ram_rdata;

   // Evaluated entry
   logic [1:0]    rd_kind;
   logic [AW-1:0] rd_first;
   logic [AW-1:0] rd_last;
   logic          rd_used;
   logic          rd_free;
   logic          hit;

   // Derived addresses
   logic [AW-1:0] new_first;
   logic [AW-1:0] new_last;
   logic [AW-1:0] head_first;
   logic [AW-1:0] rs_dec;
   logic [AW-1:0] re_inc;
   logic [SIZE_BITS-1:0] size_dec;
   logic [FIELD_ADDR_BITS-1:0] slot_wide;

   ffra_ram #(
      .WIDTH (EW),
      .DEPTH (SLOT_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (scan_ptr_ff),
      .rd_data (ram_rdata)
   );

   // Split the entry read during the scan
   always_comb begin
      rd_kind  = ram_rdata[EW-1 -: 2];
      rd_first = ram_rdata[2*AW-1 -: AW];
      rd_last  = ram_rdata[AW-1:0];
      rd_used  = used_ff[eval_ptr_ff];
      rd_free  = rd_used && (rd_kind == KIND_FREE);
   end

   // Address arithmetic for the update and response
   always_comb begin
      size_dec   = size_ff - SIZE_BITS'(1);
      rs_dec     = rs_ff - AW'(1);
      re_inc     = re_ff + AW'(1);
      new_first  = (op_ff == OP_ALLOC) ? f_first_ff : rs_ff;
      new_last   = (op_ff == OP_ALLOC) ? AW'(SIZE_BITS'(f_first_ff) + size_dec) : re_ff;
      head_first = (op_ff == OP_ALLOC) ? AW'(SIZE_BITS'(f_first_ff) + size_ff) : re_inc;
   end

   // Match test for the entry under evaluation
   always_comb begin
      case (op_ff)
         OP_ALLOC: begin
            hit = rd_free && (size_ff != '0) && (rd_first <= rd_last) &&
                  (SIZE_BITS'(rd_last - rd_first) >= size_dec);
         end
         OP_REGION: begin
            hit = rd_free && (rs_ff <= re_ff) && (rd_first <= rs_ff) &&
                  (rd_last >= re_ff);
         end
         OP_ITERATE: begin
            hit = rd_used && (32'(eval_ptr_ff) >= 32'(idx_ff));
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   // Configuration writes
   always_comb begin
      pool_start_in = pool_start_ff;
      pool_end_in   = pool_end_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_POOL_START: pool_start_in = csr_wdata[AW-1:0];
            CSR_POOL_END:   pool_end_in   = csr_wdata[AW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Request capture, scan pointer and candidate tracking
   always_comb begin
      op_in       = op_ff;
      size_in     = size_ff;
      rs_in       = rs_ff;
      re_in       = re_ff;
      kind_in     = kind_ff;
      idx_in      = idx_ff;
      scan_ptr_in = scan_ptr_ff;
      eval_ptr_in = scan_ptr_ff;
      eval_vld_in = cmd.scan_issue;
      f_found_in  = f_found_ff;
      f_slot_in   = f_slot_ff;
      f_kind_in   = f_kind_ff;
      f_first_in  = f_first_ff;
      f_last_in   = f_last_ff;
      u_found_in  = u_found_ff;
      u_slot_in   = u_slot_ff;
      v_found_in  = v_found_ff;
      v_slot_in   = v_slot_ff;

      if (cmd.load) begin
         op_in       = req_opcode;
         size_in     = req_alloc_size;
         rs_in       = req_region_start[AW-1:0];
         re_in       = req_region_end[AW-1:0];
         kind_in     = (req_entry_kind == KIND_DIR) ? KIND_DIR : KIND_FILE;
         idx_in      = req_slot_index;
         scan_ptr_in = '0;
         f_found_in  = 1'b0;
         u_found_in  = 1'b0;
         v_found_in  = 1'b0;
      end else begin
         // Advance the read pointer
         if (cmd.scan_issue) begin
            scan_ptr_in = scan_ptr_ff + SW'(1);
         end
         // Keep the first match and the first two unused slots
         if (eval_vld_ff) begin
            if (hit && !f_found_ff) begin
               f_found_in = 1'b1;
               f_slot_in  = eval_ptr_ff;
               f_kind_in  = rd_kind;
               f_first_in = rd_first;
               f_last_in  = rd_last;
            end
            if (!rd_used) begin
               if (!u_found_ff) begin
                  u_found_in = 1'b1;
                  u_slot_in  = eval_ptr_ff;
               end else if (!v_found_ff) begin
                  v_found_in = 1'b1;
                  v_slot_in  = eval_ptr_ff;
               end
            end
         end
      end
   end

   // Table updates
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = f_slot_ff;
      ram_wdata = {KIND_FREE, f_first_ff, f_last_ff};
      used_in   = used_ff;
      case (cmd.wr_sel)
         WR_FORMAT: begin
            ram_we     = 1'b1;
            ram_waddr  = '0;
            ram_wdata  = {KIND_FREE, pool_start_ff, pool_end_ff};
            used_in    = '0;
            used_in[0] = 1'b1;
         end
         WR_NEW: begin
            ram_we             = 1'b1;
            ram_waddr          = u_slot_ff;
            ram_wdata          = {kind_ff, new_first, new_last};
            used_in[u_slot_ff] = 1'b1;
         end
         WR_HEAD: begin
            ram_we    = 1'b1;
            ram_wdata = {KIND_FREE, head_first, f_last_ff};
         end
         WR_TAIL: begin
            ram_we    = 1'b1;
            ram_wdata = {KIND_FREE, f_first_ff, rs_dec};
         end
         WR_SPLIT: begin
            ram_we             = 1'b1;
            ram_waddr          = v_slot_ff;
            ram_wdata          = {KIND_FREE, re_inc, f_last_ff};
            used_in[v_slot_ff] = 1'b1;
         end
         WR_DROP: begin
            used_in[f_slot_ff] = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Response payload select
   always_comb begin
      rsp_vld_in    = cmd.respond;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;
      slot_wide     = '0;
      if (cmd.respond) begin
         rsp_status_in = cmd.rsp_status;
         case (cmd.rsp_src)
            SRC_FORMAT: begin
               rsp_kind_in  = KIND_FREE;
               rsp_start_in = FIELD_ADDR_BITS'(pool_start_ff);
               rsp_end_in   = FIELD_ADDR_BITS'(pool_end_ff);
            end
            SRC_NEW: begin
               slot_wide    = FIELD_ADDR_BITS'(u_slot_ff);
               rsp_kind_in  = kind_ff;
               rsp_start_in = FIELD_ADDR_BITS'(new_first);
               rsp_end_in   = FIELD_ADDR_BITS'(new_last);
            end
            SRC_FOUND: begin
               slot_wide    = FIELD_ADDR_BITS'(f_slot_ff);
               rsp_kind_in  = f_kind_ff;
               rsp_start_in = FIELD_ADDR_BITS'(f_first_ff);
               rsp_end_in   = FIELD_ADDR_BITS'(f_last_ff);
            end
            default: begin
               rsp_kind_in  = KIND_UNUSED;
               rsp_start_in = '0;
               rsp_end_in   = '0;
            end
         endcase
         rsp_slot_in = slot_wide[SLOT_FIELD_BITS-1:0];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_start_ff <= '0;
         pool_end_ff   <= '1;
         used_ff       <= '0;
         eval_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         pool_start_ff <= pool_start_in;
         pool_end_ff   <= pool_end_in;
         used_ff       <= used_in;
         eval_vld_ff   <= eval_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      size_ff       <= size_in;
      rs_ff         <= rs_in;
      re_ff         <= re_in;
      kind_ff       <= kind_in;
      idx_ff        <= idx_in;
      scan_ptr_ff   <= scan_ptr_in;
      eval_ptr_ff   <= eval_ptr_in;
      f_found_ff    <= f_found_in;
      f_slot_ff     <= f_slot_in;
      f_kind_ff     <= f_kind_in;
      f_first_ff    <= f_first_in;
      f_last_ff     <= f_last_in;
      u_found_ff    <= u_found_in;
      u_slot_ff     <= u_slot_in;
      v_found_ff    <= v_found_in;
      v_slot_ff     <= v_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
   end

   // Status toward the controller
   always_comb begin
      stat.op         = op_ff;
      stat.f_found    = f_found_ff;
      stat.u_found    = u_found_ff;
      stat.v_found    = v_found_ff;
      stat.head_eq    = (f_first_ff == rs_ff);
      stat.tail_eq    = (f_last_ff == re_ff);
      stat.exact      = (SIZE_BITS'(f_last_ff - f_first_ff) == size_dec);
      stat.issue_last = (scan_ptr_ff == SW'(SLOT_COUNT - 1));
   end

   assign rsp_strobe       = rsp_vld_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_slot  = rsp_slot_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_result_start = rsp_start_ff;
   assign rsp_result_end   = rsp_end_ff;

endmodule

### hw/rtl/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// Allocator controller: sequences the table scan, picks the outcome of each
// request and steps through the table writes.
// ----------------------------------------------------------------------------
module ffra_ctrl
   import ffra_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_opcode,
   input  stat_type   stat,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;
   logic      split;
   logic      alloc_fail;

   always_comb begin
      split      = !stat.head_eq && !stat.tail_eq;
      alloc_fail = !stat.f_found || !stat.u_found ||
                   ((stat.op == OP_REGION) && split && !stat.v_found);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = (req_opcode == OP_FORMAT) ? S_FORMAT : S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.issue_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if ((stat.op == OP_ITERATE) || alloc_fail) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_NEW;
            end
         end
         S_NEW: begin
            state_in = S_FIX;
         end
         S_FIX: begin
            state_in = ((stat.op == OP_REGION) && split) ? S_SPLIT : S_IDLE;
         end
         S_SPLIT: begin
            state_in = S_IDLE;
         end
         S_FORMAT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd.load       = 1'b0;
      cmd.scan_issue = 1'b0;
      cmd.wr_sel     = WR_NONE;
      cmd.respond    = 1'b0;
      cmd.rsp_status = ST_OK;
      cmd.rsp_src    = SRC_NONE;
      busy           = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
         end
         S_DECIDE: begin
            if (stat.op == OP_ITERATE) begin
               cmd.respond = 1'b1;
               if (stat.f_found) begin
                  cmd.rsp_src = SRC_FOUND;
               end else begin
                  cmd.rsp_status = ST_NONE;
               end
            end else if (!stat.f_found) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_NOFIT;
            end else if (alloc_fail) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_FULL;
            end
         end
         S_NEW: begin
            cmd.wr_sel = WR_NEW;
         end
         S_FIX: begin
            // Shrink, trim or drop the free slot that was carved from
            if (stat.op == OP_ALLOC) begin
               cmd.wr_sel = stat.exact ? WR_DROP : WR_HEAD;
            end else if (stat.head_eq) begin
               cmd.wr_sel = stat.tail_eq ? WR_DROP : WR_HEAD;
            end else begin
               cmd.wr_sel = WR_TAIL;
            end
            if (!((stat.op == OP_REGION) && split)) begin
               cmd.respond = 1'b1;
               cmd.rsp_src = SRC_NEW;
            end
         end
         S_SPLIT: begin
            cmd.wr_sel  = WR_SPLIT;
            cmd.respond = 1'b1;
            cmd.rsp_src = SRC_NEW;
         end
         S_FORMAT: begin
            cmd.wr_sel  = WR_FORMAT;
            cmd.respond = 1'b1;
            cmd.rsp_src = SRC_FORMAT;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
